FILE: hw/rtl/pts_pkg.sv
// Package for the priority thread scheduler.
// Holds the command and status codes and the semaphore constants.
// No dependencies.
`default_nettype none
package pts_pkg;

    // Command codes carried by one input item.
    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_SLICE  = 3'd1,
        CMD_TICK   = 3'd2,
        CMD_SLEEP  = 3'd3,
        CMD_WAIT   = 3'd4,
        CMD_SIGNAL = 3'd5,
        CMD_SET    = 3'd6,
        CMD_KILL   = 3'd7
    } t_cmd;

    // Status codes returned with each result item.
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_LAST = 2'd2;
    localparam logic [1:0] STAT_NONE = 2'd3;

    // Operations on the semaphore bank.
    typedef enum logic [1:0] {
        SEM_NOP = 2'd0,
        SEM_DEC = 2'd1,
        SEM_INC = 2'd2,
        SEM_LD  = 2'd3
    } t_sem_op;

    // The semaphore index is three bits wide, so at most eight counters are reachable.
    localparam int SEM_DEPTH = 8;
    localparam logic signed [15:0] SEM_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SEM_MIN = 16'sh8000;

    // Sleep value of zero means the thread is not sleeping.
    localparam logic [31:0] SLEEP_ZERO = 32'h0000_0000;

endpackage
`default_nettype wire

FILE: hw/rtl/pts_ram.sv
// Simple dual-port synchronous RAM for the scheduler thread table.
// One write and one registered read per cycle; no package dependency.
`default_nettype none
module pts_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: hw/rtl/pts_sem_bank.sv
// Bank of saturating signed counting semaphores.
// Depends on pts_pkg for the operation codes and limits.
`default_nettype none
module pts_sem_bank (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  pts_pkg::t_sem_op     i_op,
    input  wire [2:0]            i_idx,
    input  wire signed [15:0]    i_value,
    output logic signed [15:0]   o_next
);

    logic signed [15:0] r_cnt [pts_pkg::SEM_DEPTH];
    logic signed [15:0] cur;

    assign cur = r_cnt[i_idx];

    // Updated count of the addressed semaphore for the requested operation.
    always_comb begin
        case (i_op)
            pts_pkg::SEM_DEC: o_next = (cur == pts_pkg::SEM_MIN) ? cur : cur - 16'sd1;
            pts_pkg::SEM_INC: o_next = (cur == pts_pkg::SEM_MAX) ? cur : cur + 16'sd1;
            pts_pkg::SEM_LD:  o_next = i_value;
            default:          o_next = cur;
        endcase
    end

    // Counters clear on reset and take the new value on any operation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < pts_pkg::SEM_DEPTH; k++) begin
                r_cnt[k] <= 16'sd0;
            end
        end else if (i_op != pts_pkg::SEM_NOP) begin
            r_cnt[i_idx] <= o_next;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/priority_thread_scheduler.sv
// Top level of the priority thread scheduler: command sequencer over the thread table.
// Depends on pts_pkg, pts_ram and pts_sem_bank.
//
// Channel   Direction  Ports                                         Handshake
// command   in         i_command, i_priority_req, i_sleep_time,      start & !busy
//                      i_sem_index, i_sem_value
// result    out        o_running_slot, o_running_id, o_status        o_valid, one cycle
//
// Set, full add, first add, last kill and idle commands: o_valid one cycle after start.
// Time slice, signal, add and kill walk the ring one slot a cycle over the table RAM port.
// Sleep and a blocking wait do a read-modify-write of the running slot (S_CURW, S_START)
// before the walk. The ms tick sweeps every slot. Reset is synchronous and clears all
// control state; table contents are only read after an add has written them. Results
// cannot be stalled.
`default_nettype none
module priority_thread_scheduler #(
    parameter int MAX_THREADS    = 16,
    parameter int NUM_SEMAPHORES = 8
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire [2:0]          i_command,
    input  wire [7:0]          i_priority_req,
    input  wire [31:0]         i_sleep_time,
    input  wire [2:0]          i_sem_index,
    input  wire signed [15:0]  i_sem_value,
    output logic               o_valid,
    output logic [3:0]         o_running_slot,
    output logic [15:0]        o_running_id,
    output logic [1:0]         o_status
);

    localparam int SW = $clog2(MAX_THREADS);
    localparam int LW = $clog2(MAX_THREADS + 1);

    // One thread table entry.
    typedef struct packed {
        logic [15:0]   id;
        logic [SW-1:0] nxt;
        logic [2:0]    bon;
        logic          blk;
        logic [31:0]   sleep;
        logic [7:0]    prio;
    } t_entry;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CURW  = 7'b0000010,
        S_START = 7'b0000100,
        S_WALK  = 7'b0001000,
        S_ADDW  = 7'b0010000,
        S_KILLW = 7'b0100000,
        S_TICK  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    pts_pkg::t_cmd r_cmd, n_cmd;
    logic [7:0]    r_prio, n_prio;
    logic [31:0]   r_stime, n_stime;
    logic [2:0]    r_idx, n_idx;
    logic [SW-1:0] r_cur, n_cur;
    logic [15:0]   r_cur_id, n_cur_id;
    logic [LW-1:0] r_live, n_live;
    logic [15:0]   r_idc, n_idc;
    logic [MAX_THREADS-1:0] r_used, n_used;
    logic [1:0]    r_status, n_status;
    logic          r_valid, n_valid;
    logic [SW-1:0] r_t, n_t;
    logic          r_head, n_head;
    logic [SW-1:0] r_prev, n_prev;
    t_entry        r_prev_ent, n_prev_ent;
    logic [SW-1:0] r_knext, n_knext;
    logic [15:0]   r_first_id, n_first_id;
    logic [SW-1:0] r_best, n_best;
    logic [8:0]    r_bestp, n_bestp;
    logic [15:0]   r_best_id, n_best_id;
    logic [SW-1:0] r_new, n_new;
    logic [15:0]   r_new_id, n_new_id;
    logic [SW:0]   r_i, n_i;

    logic          mem_we;
    logic [SW-1:0] mem_waddr, mem_raddr;
    t_entry        mem_wdata, d;
    logic [$bits(t_entry)-1:0] ram_q;

    pts_pkg::t_sem_op sem_op;
    logic signed [15:0] sem_next;

    logic          accept, alive, sem_ok, full, cand, found;
    logic [SW-1:0] free_slot, sel, tick_wa;
    logic [15:0]   sel_id, nid, first_id_eff;
    logic [SW+3:0] slot_ext;
    pts_pkg::t_cmd in_cmd;

    pts_ram #(
        .DEPTH (MAX_THREADS),
        .WIDTH ($bits(t_entry))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (ram_q)
    );

    pts_sem_bank u_sem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (sem_op),
        .i_idx   (i_sem_index),
        .i_value (i_sem_value),
        .o_next  (sem_next)
    );

    assign d      = t_entry'(ram_q);
    assign in_cmd = pts_pkg::t_cmd'(i_command);
    assign busy   = (r_state != S_IDLE);
    assign accept = start && (r_state == S_IDLE);
    assign alive  = (r_live != '0);
    assign sem_ok = (32'(i_sem_index) < NUM_SEMAPHORES);
    assign full   = &r_used;
    assign nid    = (r_idc == 16'hFFFF) ? 16'd1 : r_idc + 16'd1;

    // Lowest free slot.
    always_comb begin
        free_slot = '0;
        for (int k = MAX_THREADS - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                free_slot = SW'(k);
            end
        end
    end

    // Pick evaluation for the slot whose entry is on the read port.
    assign cand = (d.sleep == pts_pkg::SLEEP_ZERO) && !d.blk && ({1'b0, d.prio} < r_bestp)
                  && !((r_cmd == pts_pkg::CMD_KILL) && (r_t == r_cur));
    assign found        = cand || !r_bestp[8];
    assign sel          = cand ? r_t : r_best;
    assign sel_id       = cand ? d.id : r_best_id;
    assign first_id_eff = (r_prev == r_cur) ? d.id : r_first_id;
    assign tick_wa      = SW'(r_i - 1'b1);

    // Sequencer: next state, table accesses and semaphore operations.
    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_prio     = r_prio;
        n_stime    = r_stime;
        n_idx      = r_idx;
        n_cur      = r_cur;
        n_cur_id   = r_cur_id;
        n_live     = r_live;
        n_idc      = r_idc;
        n_used     = r_used;
        n_status   = r_status;
        n_valid    = 1'b0;
        n_t        = r_t;
        n_head     = r_head;
        n_prev     = r_prev;
        n_prev_ent = r_prev_ent;
        n_knext    = r_knext;
        n_first_id = r_first_id;
        n_best     = r_best;
        n_bestp    = r_bestp;
        n_best_id  = r_best_id;
        n_new      = r_new;
        n_new_id   = r_new_id;
        n_i        = r_i;
        mem_we     = 1'b0;
        mem_waddr  = r_cur;
        mem_wdata  = d;
        mem_raddr  = r_cur;
        sem_op     = pts_pkg::SEM_NOP;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd    = in_cmd;
                    n_prio   = i_priority_req;
                    n_stime  = i_sleep_time;
                    n_idx    = i_sem_index;
                    n_status = pts_pkg::STAT_OK;
                    n_t      = r_cur;
                    n_head   = 1'b1;
                    case (in_cmd)
                        pts_pkg::CMD_ADD: begin
                            if (full) begin
                                n_status = pts_pkg::STAT_FULL;
                                n_valid  = 1'b1;
                            end else if (!alive) begin
                                mem_we          = 1'b1;
                                mem_waddr       = free_slot;
                                mem_wdata.prio  = i_priority_req;
                                mem_wdata.sleep = pts_pkg::SLEEP_ZERO;
                                mem_wdata.blk   = 1'b0;
                                mem_wdata.bon   = 3'd0;
                                mem_wdata.nxt   = free_slot;
                                mem_wdata.id    = nid;
                                n_cur           = free_slot;
                                n_cur_id        = nid;
                                n_idc           = nid;
                                n_live          = r_live + 1'b1;
                                n_used[free_slot] = 1'b1;
                                n_valid         = 1'b1;
                            end else begin
                                n_new    = free_slot;
                                n_new_id = nid;
                                n_state  = S_WALK;
                            end
                        end
                        pts_pkg::CMD_SLICE: begin
                            if (!alive) begin
                                n_status = pts_pkg::STAT_NONE;
                                n_valid  = 1'b1;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        pts_pkg::CMD_TICK: begin
                            n_i     = '0;
                            n_state = S_TICK;
                        end
                        pts_pkg::CMD_SLEEP: begin
                            if (!alive) begin
                                n_status = pts_pkg::STAT_NONE;
                                n_valid  = 1'b1;
                            end else begin
                                n_state = S_CURW;
                            end
                        end
                        pts_pkg::CMD_WAIT: begin
                            if (!alive) begin
                                n_status = pts_pkg::STAT_NONE;
                                n_valid  = 1'b1;
                            end else if (!sem_ok) begin
                                n_valid = 1'b1;
                            end else begin
                                sem_op = pts_pkg::SEM_DEC;
                                if (sem_next < 16'sd0) begin
                                    n_state = S_CURW;
                                end else begin
                                    n_valid = 1'b1;
                                end
                            end
                        end
                        pts_pkg::CMD_SIGNAL: begin
                            if (!sem_ok) begin
                                n_valid = 1'b1;
                            end else begin
                                sem_op = pts_pkg::SEM_INC;
                                if ((sem_next <= 16'sd0) && alive) begin
                                    n_state = S_WALK;
                                end else begin
                                    n_valid = 1'b1;
                                end
                            end
                        end
                        pts_pkg::CMD_SET: begin
                            if (sem_ok) begin
                                sem_op = pts_pkg::SEM_LD;
                            end
                            n_valid = 1'b1;
                        end
                        default: begin
                            // Kill of the running thread.
                            if (!alive) begin
                                n_status = pts_pkg::STAT_NONE;
                                n_valid  = 1'b1;
                            end else if (r_live == LW'(1)) begin
                                n_live        = '0;
                                n_used[r_cur] = 1'b0;
                                n_status      = pts_pkg::STAT_LAST;
                                n_valid       = 1'b1;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                    endcase
                end
            end

            // Write back the running slot for sleep or a blocking wait.
            S_CURW: begin
                mem_we    = 1'b1;
                mem_waddr = r_cur;
                if (r_cmd == pts_pkg::CMD_SLEEP) begin
                    mem_wdata.sleep = r_stime;
                end else begin
                    mem_wdata.blk = 1'b1;
                    mem_wdata.bon = r_idx;
                end
                n_state = S_START;
            end

            // Read of the running slot goes out here after its write.
            S_START: begin
                n_t     = r_cur;
                n_head  = 1'b1;
                n_state = S_WALK;
            end

            // Ring walk, one slot a cycle; d is the entry of slot r_t.
            S_WALK: begin
                mem_raddr  = d.nxt;
                n_t        = d.nxt;
                n_prev     = r_t;
                n_prev_ent = d;
                n_head     = 1'b0;
                if (r_cmd == pts_pkg::CMD_ADD) begin
                    if (d.nxt == r_cur) begin
                        mem_we        = 1'b1;
                        mem_waddr     = r_t;
                        mem_wdata.nxt = r_new;
                        n_state       = S_ADDW;
                    end
                end else if (r_cmd == pts_pkg::CMD_SIGNAL) begin
                    if (!r_head) begin
                        if (d.blk && (d.bon == r_idx)) begin
                            mem_we        = 1'b1;
                            mem_waddr     = r_t;
                            mem_wdata.blk = 1'b0;
                            n_valid       = 1'b1;
                            n_state       = S_IDLE;
                        end else if (r_t == r_cur) begin
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                end else if (r_head) begin
                    n_knext = d.nxt;
                    n_bestp = 9'h100;
                end else begin
                    if (cand) begin
                        n_best    = r_t;
                        n_bestp   = {1'b0, d.prio};
                        n_best_id = d.id;
                    end
                    if (r_prev == r_cur) begin
                        n_first_id = d.id;
                    end
                    if (r_t == r_cur) begin
                        n_prev     = r_prev;
                        n_prev_ent = r_prev_ent;
                        if (found) begin
                            n_cur    = sel;
                            n_cur_id = sel_id;
                            n_status = pts_pkg::STAT_OK;
                        end else begin
                            n_status = pts_pkg::STAT_NONE;
                        end
                        if (r_cmd == pts_pkg::CMD_KILL) begin
                            n_used[r_cur] = 1'b0;
                            if (!found) begin
                                n_cur    = r_knext;
                                n_cur_id = first_id_eff;
                            end
                            n_state = S_KILLW;
                        end else begin
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                end
            end

            // Write the added thread, linked just before the running one.
            S_ADDW: begin
                mem_we          = 1'b1;
                mem_waddr       = r_new;
                mem_wdata.prio  = r_prio;
                mem_wdata.sleep = pts_pkg::SLEEP_ZERO;
                mem_wdata.blk   = 1'b0;
                mem_wdata.bon   = 3'd0;
                mem_wdata.nxt   = r_cur;
                mem_wdata.id    = r_new_id;
                n_idc           = r_new_id;
                n_live          = r_live + 1'b1;
                n_used[r_new]   = 1'b1;
                n_valid         = 1'b1;
                n_state         = S_IDLE;
            end

            // Unlink the killed slot from its predecessor.
            S_KILLW: begin
                mem_we        = 1'b1;
                mem_waddr     = r_prev;
                mem_wdata     = r_prev_ent;
                mem_wdata.nxt = r_knext;
                n_live        = r_live - 1'b1;
                n_valid       = 1'b1;
                n_state       = S_IDLE;
            end

            // Sweep: read slot r_i while writing back slot r_i - 1.
            S_TICK: begin
                mem_raddr = SW'(r_i);
                if (r_i != '0) begin
                    mem_waddr = tick_wa;
                    mem_we    = r_used[tick_wa];
                    if (d.sleep != pts_pkg::SLEEP_ZERO) begin
                        mem_wdata.sleep = d.sleep - 32'd1;
                    end
                end
                if (r_i == (SW+1)'(MAX_THREADS)) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state with synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cur    <= '0;
            r_cur_id <= '0;
            r_live   <= '0;
            r_idc    <= '0;
            r_used   <= '0;
            r_status <= pts_pkg::STAT_OK;
            r_valid  <= 1'b0;
            r_head   <= 1'b0;
            r_i      <= '0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_cur_id <= n_cur_id;
            r_live   <= n_live;
            r_idc    <= n_idc;
            r_used   <= n_used;
            r_status <= n_status;
            r_valid  <= n_valid;
            r_head   <= n_head;
            r_i      <= n_i;
        end
    end

    // Payload and walk registers.
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_prio     <= n_prio;
        r_stime    <= n_stime;
        r_idx      <= n_idx;
        r_t        <= n_t;
        r_prev     <= n_prev;
        r_prev_ent <= n_prev_ent;
        r_knext    <= n_knext;
        r_first_id <= n_first_id;
        r_best     <= n_best;
        r_bestp    <= n_bestp;
        r_best_id  <= n_best_id;
        r_new      <= n_new;
        r_new_id   <= n_new_id;
    end

    // Result ports.
    assign slot_ext       = {4'b0000, r_cur};
    assign o_valid        = r_valid;
    assign o_running_slot = slot_ext[3:0];
    assign o_running_id   = alive ? r_cur_id : 16'd0;
    assign o_status       = r_status;

endmodule
`default_nettype wire

FILE: tb/tb_priority_thread_scheduler.sv
// Self-checking testbench for the priority thread scheduler.
// Drives commands through start/busy, predicts each result in a behavioral model
// and checks it on o_valid. Depends on pts_pkg and the scheduler RTL.
`default_nettype none
module tb_priority_thread_scheduler;
    import pts_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 16;
    localparam int NSEM = 8;
    localparam int IDLE_LIMIT = 5000;

    typedef struct packed {
        logic [3:0]  slot;
        logic [15:0] id;
        logic [1:0]  status;
    } t_sched_out;

    typedef struct {
        t_cmd              cmd;
        logic [7:0]        prio;
        logic [31:0]       stime;
        logic [2:0]        sem;
        logic signed [15:0] sval;
        bit                typed;
        t_sched_out        want;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         i_command;
    logic [7:0]         i_priority_req;
    logic [31:0]        i_sleep_time;
    logic [2:0]         i_sem_index;
    logic signed [15:0] i_sem_value;
    logic               o_valid;
    logic [3:0]         o_running_slot;
    logic [15:0]        o_running_id;
    logic [1:0]         o_status;

    priority_thread_scheduler u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_priority_req(i_priority_req),
        .i_sleep_time(i_sleep_time), .i_sem_index(i_sem_index),
        .i_sem_value(i_sem_value), .o_valid(o_valid),
        .o_running_slot(o_running_slot), .o_running_id(o_running_id),
        .o_status(o_status)
    );

    // Scheduler state mirrored by the predictor.
    logic [7:0]         m_prio [NSLOT];
    logic [31:0]        m_sleep [NSLOT];
    bit                 m_blk [NSLOT];
    logic [2:0]         m_blk_on [NSLOT];
    logic [3:0]         m_next [NSLOT];
    logic [15:0]        m_id [NSLOT];
    logic [3:0]         m_cur;
    int                 m_live;
    logic [15:0]        m_idctr;
    logic signed [15:0] m_sem [NSEM];

    t_sched_out sched_queue[$];
    int errors = 0;
    int idle_cycles = 0;
    int n_cmds = 0;
    int n_results = 0;
    int cmd_seen [8];

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // Watchdog on cycles with no accepted item or result.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[priority_thread_scheduler] ERROR");
            $finish;
        end
    end

    // Compare each result with the oldest expectation.
    always @(posedge i_clk) begin
        t_sched_out exp_r;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (sched_queue.size() == 0) begin
                $error("result with nothing expected: slot %0d id %0d status %0d",
                       o_running_slot, o_running_id, o_status);
                errors++;
            end else begin
                exp_r = sched_queue.pop_front();
                if (o_running_slot !== exp_r.slot) begin
                    $error("running_slot expected %0d actual %0d", exp_r.slot, o_running_slot);
                    errors++;
                end
                if (o_running_id !== exp_r.id) begin
                    $error("running_id expected %0d actual %0d", exp_r.id, o_running_id);
                    errors++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, o_status);
                    errors++;
                end
            end
        end
    end

    function automatic logic [3:0] ring_succ(logic [3:0] s);
        return m_next[s];
    endfunction

    // Best ready thread walking from the one after the running slot.
    function automatic bit choose_ready();
        logic [3:0] t;
        logic [3:0] best;
        int bestp;
        t = m_cur;
        best = 0;
        bestp = 256;
        for (int i = 0; i < NSLOT; i++) begin
            t = ring_succ(t);
            if (m_sleep[t] == 0 && !m_blk[t] && m_prio[t] < bestp) begin
                best = t;
                bestp = m_prio[t];
            end
            if (t == m_cur) break;
        end
        if (bestp == 256) return 1'b0;
        m_cur = best;
        return 1'b1;
    endfunction

    function automatic logic [3:0] ring_pred(logic [3:0] s);
        logic [3:0] p;
        p = s;
        for (int i = 0; i < NSLOT; i++) begin
            if (ring_succ(p) == s) break;
            p = ring_succ(p);
        end
        return p;
    endfunction

    function automatic logic signed [15:0] sat_add(logic signed [15:0] v, int d);
        int r;
        r = int'(v) + d;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < NSLOT; i++) begin
            m_prio[i] = 0; m_sleep[i] = 0; m_blk[i] = 0;
            m_blk_on[i] = 0; m_next[i] = 0; m_id[i] = 0;
        end
        for (int i = 0; i < NSEM; i++) m_sem[i] = 0;
        m_cur = 0; m_live = 0; m_idctr = 0;
    endfunction

    // Applies one command to the model and returns the scheduler's answer.
    function automatic t_sched_out schedule_cmd(t_cmd cmd, logic [7:0] prio,
            logic [31:0] stime, logic [2:0] sem, logic signed [15:0] sval);
        t_sched_out r;
        logic [1:0] st;
        bit alive;
        int i;
        logic [3:0] t;
        logic [3:0] killed;
        st = STAT_OK;
        alive = (m_live != 0);
        case (cmd)
            CMD_ADD: begin
                for (i = 0; i < NSLOT; i++) if (m_id[i] == 0) break;
                if (i == NSLOT) begin
                    st = STAT_FULL;
                end else begin
                    if (!alive) begin
                        m_cur = 4'(i);
                        m_next[i] = 4'(i);
                    end else begin
                        m_next[ring_pred(m_cur)] = 4'(i);
                        m_next[i] = m_cur;
                    end
                    m_prio[i] = prio;
                    m_live++;
                    m_idctr = m_idctr + 16'd1;
                    if (m_idctr == 0) m_idctr = 16'd1;
                    m_id[i] = m_idctr;
                    m_blk[i] = 0; m_blk_on[i] = 0; m_sleep[i] = 0;
                end
            end
            CMD_SLICE: if (!alive || !choose_ready()) st = STAT_NONE;
            CMD_TICK: begin
                for (i = 0; i < NSLOT; i++) if (m_sleep[i] != 0) m_sleep[i]--;
            end
            CMD_SLEEP: begin
                if (!alive) begin
                    st = STAT_NONE;
                end else begin
                    m_sleep[m_cur] = stime;
                    if (!choose_ready()) st = STAT_NONE;
                end
            end
            CMD_WAIT: begin
                if (!alive) begin
                    st = STAT_NONE;
                end else begin
                    m_sem[sem] = sat_add(m_sem[sem], -1);
                    if (m_sem[sem] < 0) begin
                        m_blk[m_cur] = 1;
                        m_blk_on[m_cur] = sem;
                        if (!choose_ready()) st = STAT_NONE;
                    end
                end
            end
            CMD_SIGNAL: begin
                m_sem[sem] = sat_add(m_sem[sem], 1);
                if (m_sem[sem] <= 0 && alive) begin
                    t = m_cur;
                    for (i = 0; i < NSLOT; i++) begin
                        t = ring_succ(t);
                        if (m_blk[t] && m_blk_on[t] == sem) begin
                            m_blk[t] = 0;
                            break;
                        end
                        if (t == m_cur) break;
                    end
                end
            end
            CMD_SET: m_sem[sem] = sval;
            default: begin
                killed = m_cur;
                if (!alive) begin
                    st = STAT_NONE;
                end else begin
                    m_live--;
                    if (m_live == 0) begin
                        m_id[killed] = 0; m_blk[killed] = 0;
                        st = STAT_LAST;
                    end else begin
                        m_sleep[killed] = 32'hFFFF_FFFF;
                        if (!choose_ready()) begin
                            m_cur = ring_succ(killed);
                            st = STAT_NONE;
                        end
                        m_id[killed] = 0;
                        m_blk[killed] = 0;
                        m_next[ring_pred(killed)] = ring_succ(killed);
                    end
                end
            end
        endcase
        r.slot = m_cur;
        r.id = (m_live != 0) ? m_id[m_cur] : 16'd0;
        r.status = st;
        return r;
    endfunction

    // Waits the sender's gap, presents one item and holds it until accepted.
    // Start stays high into the next item when there is no gap.
    task automatic issue(t_cmd cmd, logic [7:0] prio, logic [31:0] stime,
            logic [2:0] sem, logic signed [15:0] sval, bit typed, t_sched_out want);
        t_sched_out got;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_command <= cmd;
        i_priority_req <= prio;
        i_sleep_time <= stime;
        i_sem_index <= sem;
        i_sem_value <= sval;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        got = schedule_cmd(cmd, prio, stime, sem, sval);
        if (typed) begin
            if (got.slot !== want.slot) begin
                $error("running_slot expected %0d actual %0d", want.slot, got.slot);
                errors++;
            end
            if (got.id !== want.id) begin
                $error("running_id expected %0d actual %0d", want.id, got.id);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status expected %0d actual %0d", want.status, got.status);
                errors++;
            end
        end
        sched_queue.push_back(got);
        cmd_seen[cmd]++;
        n_cmds++;
    endtask

    // Drops start and waits until every expected result has come back.
    task automatic drain();
        start <= 1'b0;
        while (sched_queue.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_row mk(t_cmd c, logic [7:0] p, logic [31:0] s, logic [2:0] x,
            logic signed [15:0] v, bit typed, logic [3:0] ws, logic [15:0] wi,
            logic [1:0] wst);
        t_row r;
        r.cmd = c; r.prio = p; r.stime = s; r.sem = x; r.sval = v;
        r.typed = typed; r.want = '{ws, wi, wst};
        return r;
    endfunction

    t_row rows[$];
    t_cmd rc;
    int w;

    initial begin
        start = 1'b0;
        i_rst_n = 1'b0;
        i_command = CMD_TICK;
        i_priority_req = '0;
        i_sleep_time = '0;
        i_sem_index = '0;
        i_sem_value = '0;
        reset_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: empty scheduler, extremes, saturation, blocking, kills.
        rows.push_back(mk(CMD_SLICE, 0, 0, 0, 0, 1, 0, 0, STAT_NONE));
        rows.push_back(mk(CMD_KILL, 0, 0, 0, 0, 1, 0, 0, STAT_NONE));
        rows.push_back(mk(CMD_WAIT, 0, 0, 1, 0, 1, 0, 0, STAT_NONE));
        rows.push_back(mk(CMD_SIGNAL, 0, 0, 7, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_SET, 0, 0, 2, 16'sh7FFF, 0, 0, 0, 0));
        rows.push_back(mk(CMD_SIGNAL, 0, 0, 2, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_SET, 0, 0, 3, 16'sh8000, 0, 0, 0, 0));
        rows.push_back(mk(CMD_ADD, 8'd255, 0, 0, 0, 1, 0, 16'd1, STAT_OK));
        rows.push_back(mk(CMD_WAIT, 0, 0, 3, 0, 1, 0, 16'd1, STAT_NONE));
        rows.push_back(mk(CMD_ADD, 8'd0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_SLICE, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_SIGNAL, 0, 0, 3, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_SLEEP, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_ADD, 8'd7, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_SLEEP, 0, 32'd2, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_SLEEP, 0, 32'd0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_KILL, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_KILL, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_KILL, 0, 0, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < 17; i++) begin
            rows.push_back(mk(CMD_ADD, 8'(i * 15), 0, 0, 0, 0, 0, 0, 0));
        end
        foreach (rows[i]) begin
            issue(rows[i].cmd, rows[i].prio, rows[i].stime, rows[i].sem, rows[i].sval,
                  rows[i].typed, rows[i].want);
        end

        // Hold the sender back until the scheduler has answered everything.
        drain();

        // Random commands, weighted so that threads live, block, sleep and wake.
        for (int n = 0; n < 850; n++) begin
            w = $urandom_range(0, 99);
            if (w < 14) rc = CMD_ADD;
            else if (w < 30) rc = CMD_SLICE;
            else if (w < 44) rc = CMD_TICK;
            else if (w < 54) rc = CMD_SLEEP;
            else if (w < 66) rc = CMD_WAIT;
            else if (w < 80) rc = CMD_SIGNAL;
            else if (w < 88) rc = CMD_SET;
            else rc = CMD_KILL;
            issue(rc, $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3)),
                  $urandom_range(0, 4) == 0 ? 32'($urandom) : 32'($urandom_range(0, 4)),
                  3'($urandom),
                  $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3) - 1),
                  1'b0, '0);
            if (n == 400) drain();
        end

        drain();
        repeat (40) @(posedge i_clk);
        $display("Covered %0d commands and %0d results; adds %0d, waits %0d, signals %0d, kills %0d.",
                 n_cmds, n_results, cmd_seen[CMD_ADD], cmd_seen[CMD_WAIT],
                 cmd_seen[CMD_SIGNAL], cmd_seen[CMD_KILL]);
        if (errors == 0 && sched_queue.size() == 0) begin
            $display("[priority_thread_scheduler] OK");
        end else begin
            $display("[priority_thread_scheduler] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
